/* sv/uartxb_pkg.sv */
// Shared constants for the UART buffer with XON/XOFF flow control.
// No dependencies; used by uart_buffer_xon_xoff and its testbench.
package uartxb_pkg;

   // Default ring depths
   localparam int RX_DEPTH_DEF = 1024;
   localparam int TX_DEPTH_DEF = 512;

   // Byte and field widths
   localparam int BYTE_W   = 8;
   localparam int CMD_W    = 2;
   localparam int LEVEL_W  = 11;
   localparam int ERR_W    = 3;
   localparam int CSR_IDX_W = 2;

   // Request commands
   localparam logic [CMD_W-1:0] CMD_LINE_BYTE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_HOST_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HOST_WRITE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_TX_READY   = 2'd3;

   // Control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_XOFF_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_XON_LEVEL  = 2'd1;

   // Control register reset values
   localparam logic [LEVEL_W-1:0] XOFF_LEVEL_RST = 11'd300;
   localparam logic [LEVEL_W-1:0] XON_LEVEL_RST  = 11'd800;

   // Flow control characters
   localparam logic [BYTE_W-1:0] XON_BYTE  = 8'h11;
   localparam logic [BYTE_W-1:0] XOFF_BYTE = 8'h13;

   // Sticky error bit positions
   localparam int ERR_FRAME   = 0;
   localparam int ERR_NOISE   = 1;
   localparam int ERR_OVERRUN = 2;

endpackage

/* sv/uart_buffer_xon_xoff.sv */
// An accepted request is held in the pending register while the ring RAM reads, then loaded into the output register.
// A new request is taken only in the idle state, not while the last one waits on its ring RAM read or on rsp_ready.
// A finished response waits in the output register while the next request enters.
// Reset (synchronous): pointers, counts, flow state and errors clear, levels
// return to 300/800; ring RAMs are not cleared, counts keep unwritten entries unread.
module uart_buffer_xon_xoff #(
   parameter int RX_DEPTH = uartxb_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = uartxb_pkg::TX_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [uartxb_pkg::CMD_W-1:0]           req_cmd,
   input  logic [uartxb_pkg::BYTE_W-1:0]          req_data,
   input  logic                                   req_frame_error,
   input  logic                                   req_noise_error,
   input  logic                                   req_overrun_error,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [uartxb_pkg::BYTE_W-1:0]          rsp_read_data,
   output logic                                   rsp_read_valid,
   output logic [uartxb_pkg::BYTE_W-1:0]          rsp_line_data,
   output logic                                   rsp_line_valid,
   output logic                                   rsp_accepted,
   output logic [$clog2(RX_DEPTH+1)-1:0]          rsp_rx_fill,
   output logic [$clog2(TX_DEPTH+1)-1:0]          rsp_tx_fill,
   output logic                                   rsp_paused_peer,
   output logic [uartxb_pkg::ERR_W-1:0]           rsp_error_flags,
   // control register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [uartxb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [uartxb_pkg::LEVEL_W-1:0]         csr_data
);

   localparam int RX_AW  = $clog2(RX_DEPTH);
   localparam int RX_CW  = $clog2(RX_DEPTH + 1);
   localparam int TX_AW  = $clog2(TX_DEPTH);
   localparam int TX_CW  = $clog2(TX_DEPTH + 1);
   localparam int LVL_W  = uartxb_pkg::LEVEL_W;
   localparam int FREE_W = (RX_CW > LVL_W) ? RX_CW : LVL_W;
   localparam int BW     = uartxb_pkg::BYTE_W;

   localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);
   localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);
   localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
   localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

   // controller states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DATA = 1'b1;

   // where the response bytes come from
   localparam logic [1:0] SRC_NONE = 2'd0;
   localparam logic [1:0] SRC_RX   = 2'd1;
   localparam logic [1:0] SRC_TX   = 2'd2;
   localparam logic [1:0] SRC_PRIO = 2'd3;

   typedef struct packed {
      logic [1:0]                    src;
      logic                          read_valid;
      logic                          line_valid;
      logic                          accepted;
      logic [RX_CW-1:0]              rx_fill;
      logic [TX_CW-1:0]              tx_fill;
      logic                          paused;
      logic [uartxb_pkg::ERR_W-1:0]  errors;
   } pend_type;

   logic                          state_ff, state_in;
   logic [LVL_W-1:0]              xoff_level_ff, xon_level_ff;
   logic [RX_AW-1:0]              rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [RX_CW-1:0]              rx_count_ff, rx_count_in;
   logic [TX_AW-1:0]              tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [TX_CW-1:0]              tx_count_ff, tx_count_in;
   logic                          prio_valid_ff, prio_valid_in;
   logic                          paused_ff, paused_in;
   logic [uartxb_pkg::ERR_W-1:0]  sticky_ff, sticky_in;
   pend_type                      pend_ff, pend_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]                 read_data_ff, read_data_in;
   logic [BW-1:0]                 line_data_ff, line_data_in;
   pend_type                      out_ff, out_in;

   logic                          rx_we, rx_re, tx_we, tx_re;
   logic [BW-1:0]                 tx_wdata, rx_rdata, tx_rdata;
   logic [FREE_W-1:0]             rx_free;
   logic                          send_xon;
   logic                          load_out;

   // ring memories
   uartxb_ram #(.WIDTH(BW), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_head_ff),
      .wr_data (req_data),
      .rd_en   (rx_re),
      .rd_addr (rx_tail_ff),
      .rd_data (rx_rdata)
   );

   uartxb_ram #(.WIDTH(BW), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_head_ff),
      .wr_data (tx_wdata),
      .rd_en   (tx_re),
      .rd_addr (tx_tail_ff),
      .rd_data (tx_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // request decode: pointer, count and flow-control updates
   always_comb begin
      state_in      = state_ff;
      rx_head_in    = rx_head_ff;
      rx_tail_in    = rx_tail_ff;
      rx_count_in   = rx_count_ff;
      tx_head_in    = tx_head_ff;
      tx_tail_in    = tx_tail_ff;
      tx_count_in   = tx_count_ff;
      prio_valid_in = prio_valid_ff;
      paused_in     = paused_ff;
      sticky_in     = sticky_ff;
      pend_in       = pend_ff;
      rx_we         = 1'b0;
      rx_re         = 1'b0;
      tx_we         = 1'b0;
      tx_re         = 1'b0;
      tx_wdata      = req_data;
      rx_free       = '0;
      send_xon      = 1'b0;
      if (state_ff == ST_IDLE && req_valid) begin
         state_in   = ST_DATA;
         sticky_in  = sticky_ff | {req_overrun_error, req_noise_error, req_frame_error};
         pend_in.src        = SRC_NONE;
         pend_in.read_valid = 1'b0;
         pend_in.line_valid = 1'b0;
         pend_in.accepted   = 1'b0;
         unique case (req_cmd)
            uartxb_pkg::CMD_LINE_BYTE: begin
               if (rx_count_ff == RX_FULL) begin
                  sticky_in[uartxb_pkg::ERR_OVERRUN] = 1'b1;
               end else begin
                  rx_we       = 1'b1;
                  rx_head_in  = (rx_head_ff == RX_LAST) ? '0 : rx_head_ff + 1'b1;
                  rx_count_in = rx_count_ff + 1'b1;
               end
               // XOFF when free space drops to the threshold
               rx_free = FREE_W'(RX_DEPTH) - FREE_W'(rx_count_in);
               if (!paused_ff && !prio_valid_ff &&
                   rx_free <= FREE_W'(xoff_level_ff)) begin
                  prio_valid_in = 1'b1;
                  paused_in     = 1'b1;
               end
            end
            uartxb_pkg::CMD_HOST_READ: begin
               if (rx_count_ff != '0) begin
                  rx_free  = FREE_W'(RX_DEPTH) - FREE_W'(rx_count_ff - 1'b1);
                  send_xon = paused_ff && (rx_free > FREE_W'(xon_level_ff));
                  if (!(send_xon && tx_count_ff == TX_FULL)) begin
                     rx_re              = 1'b1;
                     rx_tail_in         = (rx_tail_ff == RX_LAST) ? '0 : rx_tail_ff + 1'b1;
                     rx_count_in        = rx_count_ff - 1'b1;
                     pend_in.src        = SRC_RX;
                     pend_in.read_valid = 1'b1;
                     pend_in.accepted   = 1'b1;
                     if (send_xon) begin
                        tx_we       = 1'b1;
                        tx_wdata    = uartxb_pkg::XON_BYTE;
                        tx_head_in  = (tx_head_ff == TX_LAST) ? '0 : tx_head_ff + 1'b1;
                        tx_count_in = tx_count_ff + 1'b1;
                        paused_in   = 1'b0;
                     end
                  end
               end
            end
            uartxb_pkg::CMD_HOST_WRITE: begin
               if (tx_count_ff != TX_FULL) begin
                  tx_we            = 1'b1;
                  tx_head_in       = (tx_head_ff == TX_LAST) ? '0 : tx_head_ff + 1'b1;
                  tx_count_in      = tx_count_ff + 1'b1;
                  pend_in.accepted = 1'b1;
               end
            end
            uartxb_pkg::CMD_TX_READY: begin
               // priority slot goes out before the ring
               if (prio_valid_ff) begin
                  prio_valid_in      = 1'b0;
                  pend_in.src        = SRC_PRIO;
                  pend_in.line_valid = 1'b1;
               end else if (tx_count_ff != '0) begin
                  tx_re              = 1'b1;
                  tx_tail_in         = (tx_tail_ff == TX_LAST) ? '0 : tx_tail_ff + 1'b1;
                  tx_count_in        = tx_count_ff - 1'b1;
                  pend_in.src        = SRC_TX;
                  pend_in.line_valid = 1'b1;
               end
            end
            default: begin
            end
         endcase
         pend_in.rx_fill = rx_count_in;
         pend_in.tx_fill = tx_count_in;
         pend_in.paused  = paused_in;
         pend_in.errors  = sticky_in;
      end else if (state_ff == ST_DATA && load_out) begin
         state_in = ST_IDLE;
      end
   end

   // output register: loaded once RAM read data is in, holds until taken
   assign load_out = (state_ff == ST_DATA) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      read_data_in = read_data_ff;
      line_data_in = line_data_ff;
      out_in       = out_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         out_in       = pend_ff;
         read_data_in = (pend_ff.src == SRC_RX) ? rx_rdata : '0;
         case (pend_ff.src)
            SRC_TX:   line_data_in = tx_rdata;
            SRC_PRIO: line_data_in = uartxb_pkg::XOFF_BYTE;
            default:  line_data_in = '0;
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rx_head_ff    <= '0;
         rx_tail_ff    <= '0;
         rx_count_ff   <= '0;
         tx_head_ff    <= '0;
         tx_tail_ff    <= '0;
         tx_count_ff   <= '0;
         prio_valid_ff <= 1'b0;
         paused_ff     <= 1'b0;
         sticky_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rx_head_ff    <= rx_head_in;
         rx_tail_ff    <= rx_tail_in;
         rx_count_ff   <= rx_count_in;
         tx_head_ff    <= tx_head_in;
         tx_tail_ff    <= tx_tail_in;
         tx_count_ff   <= tx_count_in;
         prio_valid_ff <= prio_valid_in;
         paused_ff     <= paused_in;
         sticky_ff     <= sticky_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      out_ff       <= out_in;
      read_data_ff <= read_data_in;
      line_data_ff <= line_data_in;
   end

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         xoff_level_ff <= uartxb_pkg::XOFF_LEVEL_RST;
         xon_level_ff  <= uartxb_pkg::XON_LEVEL_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            uartxb_pkg::CSR_XOFF_LEVEL: xoff_level_ff <= csr_data;
            uartxb_pkg::CSR_XON_LEVEL:  xon_level_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = read_data_ff;
   assign rsp_read_valid  = out_ff.read_valid;
   assign rsp_line_data   = line_data_ff;
   assign rsp_line_valid  = out_ff.line_valid;
   assign rsp_accepted    = out_ff.accepted;
   assign rsp_rx_fill     = out_ff.rx_fill;
   assign rsp_tx_fill     = out_ff.tx_fill;
   assign rsp_paused_peer = out_ff.paused;
   assign rsp_error_flags = out_ff.errors;

`ifndef SYNTH
   // ring counts never pass their depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (rx_count_ff <= RX_FULL) && (tx_count_ff <= TX_FULL))
      else $error("ring count beyond depth");

   // an accepted request always moves to the read-data cycle
   a_accept_data: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DATA))
      else $error("accepted request did not reach data cycle");

   // sticky errors never clear outside reset
   a_sticky_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (($past(sticky_ff) & ~sticky_ff) == '0))
      else $error("sticky error bit cleared");

   // a RAM read is only issued for a non-empty ring
   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rx_re |-> rx_count_ff != '0) and (tx_re |-> tx_count_ff != '0))
      else $error("read of empty ring");
`endif

endmodule

/* sv/uartxb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module uartxb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/uart_buffer_xon_xoff_tb.sv */
// Self-checking testbench for uart_buffer_xon_xoff: receive/transmit rings with XON/XOFF.
// Depends on uartxb_pkg and the uart_buffer_xon_xoff RTL; a local status predictor,
// or a fixed row of the directed table, checks every response in order.
`timescale 1ns / 100ps

module uart_buffer_xon_xoff_tb;
   import uartxb_pkg::*;

   localparam int RXD          = RX_DEPTH_DEF;
   localparam int TXD          = TX_DEPTH_DEF;
   localparam int RUN_LIMIT    = 200000;
   localparam int IDLE_PCT     = 19;
   localparam int SETTLE_TICKS = 8;

   // One response, field for field as the block reports it
   typedef struct packed {
      logic [BYTE_W-1:0]  read_data;
      logic               read_valid;
      logic [BYTE_W-1:0]  line_data;
      logic               line_valid;
      logic               accepted;
      logic [10:0]        rx_fill;
      logic [9:0]         tx_fill;
      logic               paused;
      logic [ERR_W-1:0]   errors;
   } uart_status_type;

   // Directed request; errs bits follow the sticky flag positions
   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [BYTE_W-1:0]  data;
      logic [ERR_W-1:0]   errs;
      bit                 fixed;
      uart_status_type    want;
   } step_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_cmd = CMD_LINE_BYTE;
   logic [BYTE_W-1:0]     req_data = '0;
   logic                  req_frame_error = 1'b0;
   logic                  req_noise_error = 1'b0;
   logic                  req_overrun_error = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_read_data;
   logic                  rsp_read_valid;
   logic [BYTE_W-1:0]     rsp_line_data;
   logic                  rsp_line_valid;
   logic                  rsp_accepted;
   logic [10:0]           rsp_rx_fill;
   logic [9:0]            rsp_tx_fill;
   logic                  rsp_paused_peer;
   logic [ERR_W-1:0]      rsp_error_flags;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_XOFF_LEVEL;
   logic [LEVEL_W-1:0]    csr_data = '0;

   // Predicted block state
   logic [BYTE_W-1:0]     rx_ring [RXD];
   logic [BYTE_W-1:0]     tx_ring [TXD];
   int                    rx_wr = 0, rx_rd = 0, rx_cnt = 0;
   int                    tx_wr = 0, tx_rd = 0, tx_cnt = 0;
   bit                    xoff_pending = 1'b0;
   bit                    peer_held = 1'b0;
   logic [ERR_W-1:0]      err_bits = '0;
   int                    xoff_level = XOFF_LEVEL_RST;
   int                    xon_level = XON_LEVEL_RST;

   uart_status_type       status_queue [$];
   bit                    steady = 1'b0;
   bit                    overrun_armed = 1'b0;
   int                    mismatch_count = 0;
   int                    responses_checked = 0;
   int                    requests_sent = 0;
   int                    levels_written = 0;
   int                    cycle_count = 0;

   // Directed table, written for xoff level 1022 and xon level 1023:
   // XOFF goes out at two bytes held, XON once the ring is read empty.
   step_row_type directed_steps [24] = '{
      '{CMD_HOST_READ,  'h00, 3'b000, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{CMD_TX_READY,   'h00, 3'b000, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0}},
      '{CMD_LINE_BYTE,  'h00, 3'b000, 1'b1, '{0, 0, 0, 0, 0, 1, 0, 0, 0}},
      '{CMD_LINE_BYTE,  'hFF, 3'b000, 1'b1, '{0, 0, 0, 0, 0, 2, 0, 1, 0}},
      '{CMD_LINE_BYTE,  'h80, 3'b000, 1'b1, '{0, 0, 0, 0, 0, 3, 0, 1, 0}},
      '{CMD_HOST_WRITE, 'hA5, 3'b000, 1'b1, '{0, 0, 0, 0, 1, 3, 1, 1, 0}},
      '{CMD_TX_READY,   'h00, 3'b000, 1'b1, '{0, 0, 'h13, 1, 0, 3, 1, 1, 0}},
      '{CMD_TX_READY,   'hFF, 3'b000, 1'b1, '{0, 0, 'hA5, 1, 0, 3, 0, 1, 0}},
      '{CMD_HOST_READ,  'hFF, 3'b000, 1'b1, '{'h00, 1, 0, 0, 1, 2, 0, 1, 0}},
      '{CMD_HOST_READ,  'h00, 3'b000, 1'b1, '{'hFF, 1, 0, 0, 1, 1, 0, 1, 0}},
      '{CMD_HOST_READ,  'h00, 3'b000, 1'b1, '{'h80, 1, 0, 0, 1, 0, 1, 0, 0}},
      '{CMD_TX_READY,   'h00, 3'b000, 1'b1, '{0, 0, 'h11, 1, 0, 0, 0, 0, 0}},
      '{CMD_LINE_BYTE,  'h01, 3'b000, 1'b1, '{0, 0, 0, 0, 0, 1, 0, 0, 0}},
      '{CMD_LINE_BYTE,  'h7F, 3'b001, 1'b1, '{0, 0, 0, 0, 0, 2, 0, 1, 1}},
      '{CMD_LINE_BYTE,  'h55, 3'b010, 1'b1, '{0, 0, 0, 0, 0, 3, 0, 1, 3}},
      // XON while XOFF still sits in the priority slot
      '{CMD_HOST_READ,  'h00, 3'b000, 1'b0, '0},
      '{CMD_HOST_READ,  'hFF, 3'b000, 1'b0, '0},
      '{CMD_HOST_READ,  'h00, 3'b000, 1'b0, '0},
      // threshold reached with the slot busy: no new XOFF
      '{CMD_LINE_BYTE,  'hC3, 3'b000, 1'b0, '0},
      '{CMD_LINE_BYTE,  'h3C, 3'b000, 1'b0, '0},
      '{CMD_TX_READY,   'h00, 3'b000, 1'b0, '0},
      '{CMD_TX_READY,   'h00, 3'b000, 1'b0, '0},
      '{CMD_HOST_WRITE, 'hFF, 3'b000, 1'b0, '0},
      '{CMD_TX_READY,   'h00, 3'b000, 1'b0, '0}
   };

   uart_buffer_xon_xoff dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_data          (req_data),
      .req_frame_error   (req_frame_error),
      .req_noise_error   (req_noise_error),
      .req_overrun_error (req_overrun_error),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_line_data     (rsp_line_data),
      .rsp_line_valid    (rsp_line_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_rx_fill       (rsp_rx_fill),
      .rsp_tx_fill       (rsp_tx_fill),
      .rsp_paused_peer   (rsp_paused_peer),
      .rsp_error_flags   (rsp_error_flags),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 10 ns clock
   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   function automatic void tx_enqueue(input logic [BYTE_W-1:0] b);
      tx_ring[tx_wr] = b;
      tx_wr = (tx_wr + 1) % TXD;
      tx_cnt++;
   endfunction

   // Advance the predicted state by one request and return its status
   function automatic uart_status_type apply_event(input logic [CMD_W-1:0] cmd,
         input logic [BYTE_W-1:0] data, input logic [ERR_W-1:0] errs);
      uart_status_type st;
      bit xon_due;
      st = '0;
      err_bits |= errs;
      case (cmd)
         CMD_LINE_BYTE: begin
            // full ring drops the byte, XOFF check still runs
            if (rx_cnt >= RXD) begin
               err_bits[ERR_OVERRUN] = 1'b1;
            end else begin
               rx_ring[rx_wr] = data;
               rx_wr = (rx_wr + 1) % RXD;
               rx_cnt++;
            end
            if (!peer_held && (RXD - rx_cnt) <= xoff_level && !xoff_pending) begin
               xoff_pending = 1'b1;
               peer_held = 1'b1;
            end
         end
         CMD_HOST_READ: begin
            if (rx_cnt != 0) begin
               xon_due = peer_held && ((RXD - (rx_cnt - 1)) > xon_level);
               // read refused when its XON would not fit
               if (!(xon_due && tx_cnt >= TXD)) begin
                  st.read_data = rx_ring[rx_rd];
                  st.read_valid = 1'b1;
                  st.accepted = 1'b1;
                  rx_rd = (rx_rd + 1) % RXD;
                  rx_cnt--;
                  if (xon_due) begin
                     tx_enqueue(XON_BYTE);
                     peer_held = 1'b0;
                  end
               end
            end
         end
         CMD_HOST_WRITE: begin
            if (tx_cnt < TXD) begin
               tx_enqueue(data);
               st.accepted = 1'b1;
            end
         end
         CMD_TX_READY: begin
            // priority slot goes first
            if (xoff_pending) begin
               st.line_data = XOFF_BYTE;
               st.line_valid = 1'b1;
               xoff_pending = 1'b0;
            end else if (tx_cnt != 0) begin
               st.line_data = tx_ring[tx_rd];
               st.line_valid = 1'b1;
               tx_rd = (tx_rd + 1) % TXD;
               tx_cnt--;
            end
         end
      endcase
      st.rx_fill = rx_cnt[10:0];
      st.tx_fill = tx_cnt[9:0];
      st.paused = peer_held;
      st.errors = err_bits;
      return st;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_status(input uart_status_type got, input uart_status_type want);
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", got.read_data, want.read_data);
      if (got.read_valid !== want.read_valid)
         report_mismatch("read_valid", got.read_valid, want.read_valid);
      if (got.line_data !== want.line_data)
         report_mismatch("line_data", got.line_data, want.line_data);
      if (got.line_valid !== want.line_valid)
         report_mismatch("line_valid", got.line_valid, want.line_valid);
      if (got.accepted !== want.accepted)
         report_mismatch("accepted", got.accepted, want.accepted);
      if (got.rx_fill !== want.rx_fill)
         report_mismatch("rx_fill", got.rx_fill, want.rx_fill);
      if (got.tx_fill !== want.tx_fill)
         report_mismatch("tx_fill", got.tx_fill, want.tx_fill);
      if (got.paused !== want.paused)
         report_mismatch("paused_peer", got.paused, want.paused);
      if (got.errors !== want.errors)
         report_mismatch("error_flags", got.errors, want.errors);
   endtask

   // Line error bits are rare so the sticky flags stay informative
   function automatic logic [ERR_W-1:0] random_errors();
      logic [ERR_W-1:0] e;
      e = '0;
      e[ERR_FRAME] = ($urandom_range(49) == 0);
      e[ERR_NOISE] = ($urandom_range(49) == 0);
      e[ERR_OVERRUN] = overrun_armed && ($urandom_range(49) == 0);
      return e;
   endfunction

   // Present one request, hold it until taken, then record its expected status
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
         input logic [ERR_W-1:0] errs, input bit fixed = 1'b0,
         input uart_status_type want = '0);
      uart_status_type predicted;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_data <= data;
      req_frame_error <= errs[ERR_FRAME];
      req_noise_error <= errs[ERR_NOISE];
      req_overrun_error <= errs[ERR_OVERRUN];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_event(cmd, data, errs);
      status_queue.push_back(fixed ? want : predicted);
      requests_sent++;
   endtask

   // Stop requesting and let every outstanding response come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_level(input logic [CSR_IDX_W-1:0] idx, input int value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[LEVEL_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_XOFF_LEVEL) xoff_level = value;
      else xon_level = value;
      levels_written++;
   endtask

   // Random requests with a given command mix, in percent
   task automatic send_mixed(input int count, input int line_pct, input int read_pct,
         input int write_pct);
      int pick;
      logic [CMD_W-1:0] cmd;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < line_pct) cmd = CMD_LINE_BYTE;
         else if (pick < line_pct + read_pct) cmd = CMD_HOST_READ;
         else if (pick < line_pct + read_pct + write_pct) cmd = CMD_HOST_WRITE;
         else cmd = CMD_TX_READY;
         send_request(cmd, 8'($urandom), random_errors());
      end
   endtask

   // Empty both rings and the priority slot, driven by the predicted fill
   task automatic empty_rings();
      while (tx_cnt != 0 || xoff_pending)
         send_request(CMD_TX_READY, 8'($urandom), random_errors());
      while (rx_cnt != 0)
         send_request(CMD_HOST_READ, 8'($urandom), random_errors());
      while (tx_cnt != 0)
         send_request(CMD_TX_READY, 8'($urandom), random_errors());
   endtask

   // Response side: random back-pressure, in-order compare
   always @(posedge clock) begin
      uart_status_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_read_data, rsp_read_valid, rsp_line_data, rsp_line_valid,
                    rsp_accepted, rsp_rx_fill, rsp_tx_fill, rsp_paused_peer,
                    rsp_error_flags};
            if (status_queue.size() == 0) begin
               report_mismatch("response with no request pending", got, 0);
            end else begin
               check_status(got, status_queue.pop_front());
               responses_checked++;
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses pending",
                  cycle_count, status_queue.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table at tight levels
      write_level(CSR_XOFF_LEVEL, 1022);
      write_level(CSR_XON_LEVEL, 1023);
      foreach (directed_steps[i])
         send_request(directed_steps[i].cmd, directed_steps[i].data, directed_steps[i].errs,
                      directed_steps[i].fixed, directed_steps[i].want);

      // default levels, balanced traffic
      write_level(CSR_XOFF_LEVEL, XOFF_LEVEL_RST);
      write_level(CSR_XON_LEVEL, XON_LEVEL_RST);
      send_mixed(80, 30, 25, 25);

      // XOFF on any byte, XON on any read
      write_level(CSR_XOFF_LEVEL, 1024);
      write_level(CSR_XON_LEVEL, 0);
      send_mixed(60, 25, 25, 25);
      empty_rings();

      // XOFF on any byte, XON never: pause the peer, then overfill the
      // transmit ring with no idling
      write_level(CSR_XON_LEVEL, 1024);
      steady = 1'b1;
      repeat (4) send_request(CMD_LINE_BYTE, 8'($urandom), random_errors());
      repeat (TXD + 3) send_request(CMD_HOST_WRITE, 8'($urandom), random_errors());
      steady = 1'b0;

      // XON due with the transmit ring full: reads refused until it drains
      write_level(CSR_XON_LEVEL, 0);
      repeat (3) send_request(CMD_HOST_READ, 8'($urandom), random_errors());
      repeat (3) send_request(CMD_TX_READY, 8'($urandom), random_errors());
      repeat (2) send_request(CMD_HOST_READ, 8'($urandom), random_errors());
      overrun_armed = 1'b1;
      send_mixed(30, 25, 25, 25);

      // random levels
      write_level(CSR_XOFF_LEVEL, $urandom_range(1024));
      write_level(CSR_XON_LEVEL, $urandom_range(1024));
      send_mixed(40, 40, 30, 15);

      wait_idle();
      $display("Checked %0d responses for %0d requests across %0d level writes",
               responses_checked, requests_sent, levels_written);
      $display("Covered transmit ring overflow, XON refused on a full transmit ring "
               , "and busy XOFF slot");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
